// ===== hw/rtl/frvp_pkg.sv =====
// Shared types, constants and helpers for the frame run varint packer.
`timescale 1ns / 1ps
`default_nettype none
package frvp_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned CtrlWords   = 4;
  localparam int unsigned CntW        = 64;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ChanW       = 4;

  localparam logic [ChanW-1:0] ChanReset = 4'd4;

  typedef logic [CtrlWords-1:0][WordW-1:0] frvp_words_t;

  // Request from the frame tracker to the byte sequencer.
  typedef struct packed {
    logic start;  // begin a byte sequence
    logic flush;  // lead with the pending frame count
    logic ctrl;   // follow with the completed control frame
  } frvp_cmd_t;

  // Status from the byte sequencer back to the frame tracker.
  typedef struct packed {
    logic busy;       // sequence in progress
    logic cnt_taken;  // count copied into the shifter, clear it now
  } frvp_sts_t;

  // Zigzag of a sign-extended 32-bit word; the result always fits in 32 bits.
  function automatic logic [WordW-1:0] zigzag(input logic [WordW-1:0] w);
    zigzag = {w[WordW-2:0] ^ {(WordW-1){w[WordW-1]}}, w[WordW-1]};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/frvp_emitter.sv =====
// Byte sequencer: shifts varints out seven bits per cycle into an output register while the receiver takes them.
`timescale 1ns / 1ps
`default_nettype none
module frvp_emitter (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  frvp_pkg::frvp_cmd_t   cmd_i,
  input  wire  [63:0]          cnt_i,
  input  wire  frvp_pkg::frvp_words_t fw_i,
  output frvp_pkg::frvp_sts_t  sts_o,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,   // [7:0] out_byte
  output logic                 m_axis_tlast_o    // last
);
  import frvp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam logic [2:0] StepCntHdr  = 3'd0;
  localparam logic [2:0] StepCnt     = 3'd1;
  localparam logic [2:0] StepHdr     = 3'd2;
  localparam logic [2:0] StepA       = 3'd3;
  localparam logic [2:0] StepB       = 3'd4;
  localparam logic [2:0] StepC       = 3'd5;
  localparam logic [2:0] StepD       = 3'd6;

  state_e             state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic               ctrl_q, ctrl_d;
  logic [CntW-1:0]    sh_q, sh_d;
  logic               vld_q, vld_d;
  logic [7:0]         data_q, data_d;
  logic               last_q, last_d;

  logic               is_time;
  logic [2:0]         last_step;
  logic [CntW-1:0]    val;
  logic               more;
  logic               out_free;

  // Plain time frame: first word one, middle words non-negative, last zero.
  assign is_time = (fw_i[0] == 32'd1) && !fw_i[1][WordW-1] && !fw_i[2][WordW-1] &&
                   (fw_i[3] == '0);
  assign last_step = !ctrl_q ? StepCnt : (is_time ? StepB : StepD);

  always_comb begin
    unique case (step_q)
      StepCntHdr: val = '0;
      StepCnt:    val = cnt_i;
      StepHdr:    val = is_time ? 64'd1 : 64'd2;
      StepA:      val = is_time ? {32'd0, fw_i[1]} : {32'd0, zigzag(fw_i[0])};
      StepB:      val = is_time ? {32'd0, fw_i[2]} : {32'd0, zigzag(fw_i[1])};
      StepC:      val = {32'd0, zigzag(fw_i[2])};
      StepD:      val = {32'd0, zigzag(fw_i[3])};
      default:    val = '0;
    endcase
  end

  assign more     = |sh_q[CntW-1:7];
  assign out_free = !vld_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ctrl_d  = ctrl_q;
    sh_d    = sh_q;
    vld_d   = vld_q && !m_axis_tready_i;
    data_d  = data_q;
    last_d  = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          state_d = ST_LOAD;
          step_d  = cmd_i.flush ? StepCntHdr : StepHdr;
          ctrl_d  = cmd_i.ctrl;
        end
      end
      ST_LOAD: begin
        sh_d    = val;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          vld_d  = 1'b1;
          data_d = {more, sh_q[6:0]};
          last_d = !more && (step_q == last_step);
          sh_d   = sh_q >> 7;
          if (!more) begin
            if (step_q == last_step) begin
              state_d = ST_IDLE;
            end else begin
              step_d  = step_q + 3'd1;
              state_d = ST_LOAD;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    ctrl_q <= ctrl_d;
    sh_q   <= sh_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign sts_o.busy      = (state_q != ST_IDLE);
  assign sts_o.cnt_taken = (state_q == ST_LOAD) && (step_q == StepCnt);

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/frame_run_varint_packer.sv =====
// Top level: frame tracking, data frame count and the varint byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Frame run varint packer.
// Input stream: one recorder word per beat on s_axis; tuser[0] set marks an end of
// stream flush, whose tdata is ignored. Output stream: one varint byte per beat
// on m_axis, tlast set on the final byte caused by an input word.
// Configuration: cfg_data_i sets the data frame length in words (0 acts as 1,
// above eight acts as eight); it is sampled when a frame starts. cfg_ready_o is
// always high; write only while the block is idle.
// Throughput: a data word that causes no output is taken at once, and words
// may follow back to back. A word that completes a control frame, or a flush
// with a pending count, starts the byte sequencer: each varint is loaded into
// the shifter and then sent one byte per shift (seven bits each), up to 7
// varints and 32 bytes in all. s_axis_tready_o stays low while the
// sequencer runs and rises as the final byte enters the output register.
// A stalled receiver freezes the sequencer; the output register holds its byte.
// Reset: frame position, count and the output stream clear at once; the frame
// length returns to four words.
module frame_run_varint_packer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [31:0] word
  input  wire  [0:0]  s_axis_tuser_i,   // [0] opcode
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,   // last
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_data_i        // data frame length
);
  import frvp_pkg::*;

  logic [ChanW-1:0]  chan_q;
  frvp_words_t       fw_q;
  logic [3:0]        rem_q, rem_d;
  logic [2:0]        pos_q, pos_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  frvp_cmd_t         cmd;
  frvp_sts_t         sts;

  logic              acc;
  logic              cnt_nz;
  logic [3:0]        eff_chan;
  logic              fw0_odd;
  logic              done;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !sts.busy;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_nz          = |cnt_q;

  // Clamp the frame length into one to eight words.
  always_comb begin
    priority if (chan_q == '0) begin
      eff_chan = 4'd1;
    end else if (chan_q > 4'(MaxChannels)) begin
      eff_chan = 4'(MaxChannels);
    end else begin
      eff_chan = chan_q;
    end
  end

  // Advance the frame position on a data word.
  always_comb begin
    rem_d   = rem_q;
    pos_d   = pos_q;
    fw0_odd = fw_q[0][0];
    if (rem_q == '0) begin
      fw0_odd = s_axis_tdata_i[0];
      rem_d   = s_axis_tdata_i[0] ? 4'(CtrlWords - 1) : eff_chan - 4'd1;
      pos_d   = 3'd1;
    end else begin
      rem_d = rem_q - 4'd1;
      pos_d = pos_q + 3'd1;
    end
  end

  assign done = (rem_d == '0);

  always_comb begin
    cmd   = '0;
    cnt_d = cnt_q;
    if (sts.cnt_taken) begin
      cnt_d = '0;
    end
    if (acc) begin
      if (s_axis_tuser_i[0]) begin
        cmd.start = cnt_nz;
        cmd.flush = cnt_nz;
      end else if (done) begin
        if (fw0_odd) begin
          cmd.start = 1'b1;
          cmd.flush = cnt_nz;
          cmd.ctrl  = 1'b1;
        end else begin
          cnt_d = cnt_q + 64'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= ChanReset;
      rem_q  <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        chan_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
      if (acc) begin
        if (s_axis_tuser_i[0]) begin
          rem_q <= '0;
          pos_q <= '0;
        end else begin
          rem_q <= rem_d;
          pos_q <= pos_d;
        end
      end
    end
  end

  // Hold only the first four words of a frame.
  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tuser_i[0]) begin
      if (rem_q == '0) begin
        fw_q[0] <= s_axis_tdata_i;
      end else if (!pos_q[2]) begin
        fw_q[pos_q[1:0]] <= s_axis_tdata_i;
      end
    end
  end

  frvp_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cnt_i           (cnt_q),
    .fw_i            (fw_q),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // A started sequence blocks the input on the next cycle.
  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !s_axis_tready_o)
    else $error("input taken right after sequence start");

  // The closing byte of an item never carries a continuation bit.
  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> !m_axis_tdata_o[7])
    else $error("last byte carries continuation bit");

  // The count is cleared once the sequencer has copied it.
  a_cnt_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.cnt_taken |=> (cnt_q == '0))
    else $error("frame count not cleared after flush");

  // A flush is only requested with a count pending.
  a_flush_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.start && cmd.flush) |-> cnt_nz)
    else $error("flush requested with empty count");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_frame_run_varint_packer.sv =====
// Self-checking testbench for the frame run varint packer: directed script, random frames.
`timescale 1ns / 1ps
module tb_frame_run_varint_packer;

  localparam logic OP_WORD  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [63:0] TAG_COUNT = 64'd0;
  localparam logic [63:0] TAG_TIME  = 64'd1;
  localparam logic [63:0] TAG_CTRL  = 64'd2;

  localparam logic [31:0] TIME_WORD = 32'd1;  // first word of a plain time frame
  localparam int unsigned CTRL_LEN  = frvp_pkg::CtrlWords;

  localparam int DRAIN       = 60;    // idle wait after the last expected byte has left
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } vbyte_t;

  // One directed item; n < 0 means the predictor supplies the expected bytes.
  typedef struct {
    logic        op;
    logic [31:0] w;
    int          n;
    logic [127:0] b;  // expected bytes, first byte in the lowest bits
  } script_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  int          s_row    = -1;  // script row travelling with the word, -1 when random

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data  = '0;

  // Predicted block state
  logic [31:0] fw [4] = '{default: '0};
  logic [3:0]  left     = '0;
  logic [2:0]  pos      = '0;
  logic [63:0] frames   = '0;
  logic [3:0]  chan_cfg = frvp_pkg::ChanReset;

  vbyte_t      step_bytes [$];
  vbyte_t      bytes_due [$];
  script_row_t script [$];

  int  errors     = 0;
  int  bytes_seen = 0;
  int  sent       = 0;
  int  stall      = 0;
  bit  idle_en    = 1'b1;
  bit  hold_req   = 1'b0;

  frame_run_varint_packer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [31:0] word
    .s_axis_tuser_i  (s_tuser),   // [0] opcode
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] out_byte
    .m_axis_tlast_o  (m_tlast),   // last
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)   // data frame length
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [3:0] frame_len(logic [3:0] c);
    if (c == 4'd0) return 4'd1;
    if (c > 4'(frvp_pkg::MaxChannels)) return 4'(frvp_pkg::MaxChannels);
    return c;
  endfunction

  function automatic logic [31:0] fold_sign(logic [31:0] w);
    return (w << 1) ^ {32{w[31]}};
  endfunction

  function automatic void put_varint(logic [63:0] v);
    while (v > 64'd127) begin
      step_bytes.push_back('{data: {1'b1, v[6:0]}, last: 1'b0});
      v = v >> 7;
    end
    step_bytes.push_back('{data: {1'b0, v[6:0]}, last: 1'b0});
  endfunction

  function automatic void flush_count();
    if (frames != 64'd0) begin
      put_varint(TAG_COUNT);
      put_varint(frames);
      frames = '0;
    end
  endfunction

  // Advance the predicted state by one accepted word and collect the bytes it causes.
  function automatic void predict_word(logic op, logic [31:0] w);
    int i;
    if (op == OP_FLUSH) begin
      flush_count();
      left = '0;
      pos  = '0;
    end else begin
      if (left == 4'd0) begin
        fw[0] = w;
        left  = w[0] ? 4'(CTRL_LEN - 1) : frame_len(chan_cfg) - 4'd1;
        pos   = 3'd1;
      end else begin
        if (pos < 3'd4) fw[pos[1:0]] = w;
        pos  = pos + 3'd1;
        left = left - 4'd1;
      end
      if (left == 4'd0) begin
        if (fw[0][0]) begin
          flush_count();
          if (fw[0] == TIME_WORD && !fw[1][31] && !fw[2][31] && fw[3] == '0) begin
            put_varint(TAG_TIME);
            put_varint({32'd0, fw[1]});
            put_varint({32'd0, fw[2]});
          end else begin
            put_varint(TAG_CTRL);
            for (i = 0; i < 4; i++) put_varint({32'd0, fold_sign(fw[i])});
          end
        end else begin
          frames = frames + 64'd1;
        end
      end
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_diff(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void add_row(logic op, logic [31:0] w, int n, logic [127:0] b);
    script_row_t r;
    r.op = op;
    r.w  = w;
    r.n  = n;
    r.b  = b;
    script.push_back(r);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0, 5: return $urandom;
      1: return $urandom_range(0, 127);
      2: return $urandom_range(128, 1 << 21);
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'd0 - 32'($urandom_range(1, 300));
    endcase
  endfunction

  // Scoreboard: predict on every accepted word, check every accepted byte.
  always @(posedge clk_i) begin : scoreboard
    int i;
    vbyte_t want;
    if (rst_ni && cfg_valid && cfg_ready) chan_cfg = cfg_data;
    if (rst_ni && s_tvalid && s_tready) begin
      step_bytes.delete();
      predict_word(s_tuser[0], s_tdata);
      if (s_row >= 0 && script[s_row].n >= 0) begin
        for (i = 0; i < script[s_row].n; i++)
          bytes_due.push_back('{data: script[s_row].b[8*i +: 8],
                                last: (i == script[s_row].n - 1)});
      end else begin
        foreach (step_bytes[i]) bytes_due.push_back(step_bytes[i]);
      end
    end
    if (rst_ni && m_tvalid && m_tready) begin
      if (bytes_due.size() == 0) begin
        report_diff($sformatf("byte %0d: unexpected data %02h last %0b",
                              bytes_seen, m_tdata, m_tlast));
      end else begin
        want = bytes_due.pop_front();
        if (m_tdata !== want.data)
          report_diff($sformatf("byte %0d: data %02h, expected %02h",
                                bytes_seen, m_tdata, want.data));
        if (m_tlast !== want.last)
          report_diff($sformatf("byte %0d: last %0b, expected %0b",
                                bytes_seen, m_tlast, want.last));
      end
      bytes_seen++;
    end
  end

  // Watchdog: cycles with no word moving on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("frame_run_varint_packer: mismatch");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // Byte receiver: random back-pressure, one long hold when asked.
  initial begin : receiver
    int gap;
    int hold_left;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_tready  <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk_i);
          hold_left--;
        end
        hold_req = 1'b0;
      end else begin
        gap = idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_word(input logic op, input logic [31:0] w, input int row);
    int gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= op;
    s_row    <= row;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_channels(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every byte is out and the sequencer has settled.
  task automatic wait_idle();
    @(posedge clk_i);
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int k;
    int p;
    int n;
    int target;
    int kind;
    logic [3:0] cfg_plan [8];

    // Directed script, four-word data frames after reset.
    add_row(OP_FLUSH, 32'h0000_0000, 0, '0);             // nothing pending after reset
    add_row(OP_WORD,  32'h0000_0001, 0, '0);             // zero time frame
    add_row(OP_WORD,  32'h0000_0000, 0, '0);
    add_row(OP_WORD,  32'h0000_0000, 0, '0);
    add_row(OP_WORD,  32'h0000_0000, 3, 24'h00_00_01);
    add_row(OP_WORD,  32'h0000_0000, 0, '0);             // data frame, extreme words
    add_row(OP_WORD,  32'hFFFF_FFFE, 0, '0);
    add_row(OP_WORD,  32'hFFFF_FFFF, 0, '0);
    add_row(OP_WORD,  32'h7FFF_FFFF, 0, '0);
    add_row(OP_FLUSH, 32'hFFFF_FFFF, 2, 16'h01_00);      // flush one pending frame
    add_row(OP_WORD,  32'hFFFF_FFFF, 0, '0);             // control frame, extreme words
    add_row(OP_WORD,  32'h8000_0000, 0, '0);
    add_row(OP_WORD,  32'h7FFF_FFFF, 0, '0);
    add_row(OP_WORD,  32'h0000_0000, 13, 104'h00_0F_FF_FF_FF_FE_0F_FF_FF_FF_FF_01_02);
    add_row(OP_WORD,  32'h0000_0001, 0, '0);             // time frame, largest values
    add_row(OP_WORD,  32'h7FFF_FFFF, 0, '0);
    add_row(OP_WORD,  32'h7FFF_FFFF, 0, '0);
    add_row(OP_WORD,  32'h0000_0000, 11, 88'h07_FF_FF_FF_FF_07_FF_FF_FF_FF_01);
    add_row(OP_WORD,  32'h0000_0002, 0, '0);             // partial data frame, then dropped
    add_row(OP_FLUSH, 32'h0000_0000, 0, '0);
    add_row(OP_WORD,  32'h0000_0001, 0, '0);             // time frame broken twice over
    add_row(OP_WORD,  32'h8000_0000, 0, '0);
    add_row(OP_WORD,  32'h0000_0005, 0, '0);
    add_row(OP_WORD,  32'h0000_0001, -1, '0);

    cfg_plan = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd2, 4'd6, 4'd3, 4'd5};
    cfg_plan[5] = 4'($urandom_range(0, 15));

    wait (rst_ni);
    @(posedge clk_i);
    for (k = 0; k < script.size(); k++) send_word(script[k].op, script[k].w, k);

    for (p = 0; p < 8; p++) begin
      s_tvalid <= 1'b0;
      wait_idle();
      write_channels(cfg_plan[p]);
      idle_en = (p % 3) != 1;
      if (p == 3) hold_req = 1'b1;  // fill the block behind a stalled receiver
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // run of data frames at the current length
          repeat ($urandom_range(1, 4)) begin
            n = frame_len(chan_cfg);
            send_word(OP_WORD, rand_word() & ~32'd1, -1);
            repeat (n - 1) send_word(OP_WORD, rand_word(), -1);
          end
        end else if (kind < 70) begin
          send_word(OP_WORD, TIME_WORD, -1);
          send_word(OP_WORD, rand_word() & 32'h7FFF_FFFF, -1);
          send_word(OP_WORD, rand_word() & 32'h7FFF_FFFF, -1);
          send_word(OP_WORD, 32'd0, -1);
        end else if (kind < 85) begin
          // general control frame, often a time frame that does not qualify
          send_word(OP_WORD, $urandom_range(0, 1) ? TIME_WORD : (rand_word() | 32'd1), -1);
          repeat (3) send_word(OP_WORD, rand_word(), -1);
        end else if (kind < 92) begin
          send_word(OP_FLUSH, rand_word(), -1);
        end else begin
          // noise: loose words and flushes that break frames
          repeat ($urandom_range(1, 3))
            send_word(($urandom_range(0, 5) == 0) ? OP_FLUSH : OP_WORD, rand_word(), -1);
        end
      end
    end

    s_tvalid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("frame_run_varint_packer: match");
    end else begin
      $display("frame_run_varint_packer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/frvp_pkg.sv
hw/rtl/frvp_emitter.sv
hw/rtl/frame_run_varint_packer.sv
dv/tb_frame_run_varint_packer.sv
